// ===== rtl/core/ffra_pkg.sv =====
package ffra_pkg;

  localparam int NUM_TYPES_DEF   = 8;
  localparam int MAX_CHUNKS_DEF  = 16;
  localparam int MAX_RANGES_DEF  = 32;
  localparam int OFFSET_BITS_DEF = 33;

  localparam logic [32:0] CHUNK_SIZE_RST = 33'd16777216;
  localparam logic [3:0]  TYPE_COUNT_RST = 4'd8;

  localparam logic [1:0] CFG_CHUNK_SIZE = 2'd0;
  localparam logic [1:0] CFG_TYPE_COUNT = 2'd1;
  localparam logic [1:0] CFG_TYPE_FLAGS = 2'd2;

  localparam logic [2:0] ST_POOLED    = 3'd0;
  localparam logic [2:0] ST_EXCLUSIVE = 3'd1;
  localparam logic [2:0] ST_NO_TYPE   = 3'd2;
  localparam logic [2:0] ST_NO_SLOT   = 3'd3;
  localparam logic [2:0] ST_LIST_FULL = 3'd4;
  localparam logic [2:0] ST_RECYCLED  = 3'd5;

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RECYCLE = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [35:0] req_size;
    logic [16:0] align_bytes;
    logic [7:0]  type_mask;
    logic [7:0]  need_flags;
    logic [3:0]  ret_chunk;
    logic [31:0] ret_offset;
    logic [32:0] ret_size;
    logic        ret_exclusive;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  type_index;
    logic [3:0]  chunk_index;
    logic [31:0] block_offset;
    logic [35:0] block_size;
    logic        is_exclusive;
  } out_t;

endpackage

// ===== rtl/core/ffra_ram.sv =====
module ffra_ram #(
  parameter int WIDTH = 66,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/first_fit_range_allocator.sv =====
// First-fit range allocator with per-type chunk pools.
// in_*: one request beat (allocate or recycle) as ffra_pkg::in_t. in_ready is
// high only while the block is idle; one request is worked at a time.
// out_*: one result beat per request as ffra_pkg::out_t, held in an output
// register until out_ready; the sequencer waits at its last step while the
// previous result is still unclaimed.
// cfg_*: register writes (chunk size, type count, type flags), always ready;
// write only while no request is in flight.
// The trivial cases (no type, exclusive, ignored recycle) go straight to the
// result. Allocate visits the free ranges of matching chunks and skips other
// chunk slots; recycle reads every free range of the chunk. Splits, merges
// and inserts shift list entries one at a time through the single write port
// of the free-list RAM.
// Reset clears chunk ownership and list counts at once; the free-list RAM
// itself is never cleared, entries past a chunk's count are not read.
module first_fit_range_allocator #(
  parameter int NUM_TYPES   = ffra_pkg::NUM_TYPES_DEF,
  parameter int MAX_CHUNKS  = ffra_pkg::MAX_CHUNKS_DEF,
  parameter int MAX_RANGES  = ffra_pkg::MAX_RANGES_DEF,
  parameter int OFFSET_BITS = ffra_pkg::OFFSET_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ffra_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ffra_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [63:0]    cfg_wdata
);

  localparam int CIW   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int CCW   = $clog2(MAX_CHUNKS + 1);
  localparam int RIW   = $clog2(MAX_RANGES);
  localparam int RCW   = $clog2(MAX_RANGES + 1);
  localparam int AW    = CIW + RIW;
  localparam int DEPTH = 1 << AW;
  localparam int OB    = OFFSET_BITS;
  localparam int DW    = 2 * OB;
  localparam int EW    = ((OFFSET_BITS > 37) ? OFFSET_BITS : 37) + 2;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_PREP  = 16'h0002,
    S_CHK   = 16'h0004,
    S_CSCAN = 16'h0008,
    S_ARD   = 16'h0010,
    S_AEV   = 16'h0020,
    S_NEWCH = 16'h0040,
    S_RCHK  = 16'h0080,
    S_RSCAN = 16'h0100,
    S_RRD   = 16'h0200,
    S_RDEC  = 16'h0400,
    S_W1    = 16'h0800,
    S_SHL   = 16'h1000,
    S_SHW   = 16'h2000,
    S_W2    = 16'h4000,
    S_DONE  = 16'h8000
  } state_t;

  typedef enum logic [1:0] {
    SH_NONE = 2'd0,
    SH_DOWN = 2'd1,
    SH_UP   = 2'd2
  } shift_t;

  state_t          state_r;
  ffra_pkg::in_t   req_r;
  ffra_pkg::out_t  res_r;
  ffra_pkg::out_t  out_data_r;
  logic            out_valid_r;

  logic [32:0]     chunk_size_r;
  logic [3:0]      type_count_r;
  logic [63:0]     type_flags_r;

  logic [MAX_CHUNKS-1:0] used_r;
  logic [2:0]            ctype_r [MAX_CHUNKS];
  logic [RCW-1:0]        fcnt_r  [MAX_CHUNKS];

  logic [16:0]     amask_r;
  logic [EW-1:0]   nsz_r;
  logic            found_r;
  logic [2:0]      t_r;
  logic [CCW-1:0]  c_r;
  logic [RCW-1:0]  k_r;
  logic [EW-1:0]   os_r, ns_r, oe_r;

  logic            p_done_r, p_found_r, s_found_r, dup_r, pos_found_r;
  logic [RCW-1:0]  p_idx_r, s_idx_r, pos_r;
  logic [OB-1:0]   plen_r, pst_r, slen_r;

  logic            w1_en_r, w2_en_r;
  logic [RCW-1:0]  w1_idx_r, sh_k_r, j_r, cnt_new_r;
  logic [DW-1:0]   w1_data_r, w2_data_r;
  shift_t          sh_mode_r;

  // RAM ports
  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [DW-1:0]   ram_wdata, ram_rdata;

  ffra_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic [CIW-1:0]  ci;
  logic [RCW-1:0]  n_cur;
  logic [RCW-1:0]  j_up, j_dn;
  logic [OB-1:0]   rd_st, rd_ln;
  logic [EW-1:0]   rd_st_e, rd_end_e;
  logic [EW-1:0]   rs_e, rsz_e, re_e, req_e;
  logic [EW-1:0]   ne;
  logic [35:0]     bsz;
  logic [16:0]     amask;
  logic            tfound;
  logic [2:0]      tsel;
  logic [CIW-1:0]  nc;
  logic            nc_ok;
  logic [3:0]      ntypes;

  assign ci      = c_r[CIW-1:0];
  assign n_cur   = fcnt_r[ci];
  assign j_up    = j_r + RCW'(1);
  assign j_dn    = j_r - RCW'(1);
  assign rd_st   = ram_rdata[DW-1:OB];
  assign rd_ln   = ram_rdata[OB-1:0];
  assign rd_st_e = EW'(rd_st);
  assign rd_end_e = EW'(rd_st) + EW'(rd_ln);
  assign rs_e    = EW'(req_r.ret_offset);
  assign rsz_e   = EW'(req_r.ret_size);
  assign re_e    = rs_e + rsz_e;
  assign req_e   = EW'(req_r.req_size);
  assign ne      = ns_r + nsz_r;
  assign bsz     = (nsz_r > EW'(36'hF_FFFF_FFFF)) ? 36'hF_FFFF_FFFF : nsz_r[35:0];

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // alignment mask, type pick and free slot search
  always_comb begin
    amask  = '0;
    tfound = 1'b0;
    tsel   = '0;
    nc     = '0;
    nc_ok  = 1'b0;
    ntypes = (type_count_r > 4'(NUM_TYPES)) ? 4'(NUM_TYPES) : type_count_r;
    for (int b = 0; b < 17; b++) begin
      if (req_r.align_bytes[b]) amask = (17'd1 << b) - 17'd1;
    end
    for (int t = NUM_TYPES - 1; t >= 0; t--) begin
      if ((4'(t) < ntypes) && req_r.type_mask[t] &&
          ((type_flags_r[8*t +: 8] & req_r.need_flags) == req_r.need_flags)) begin
        tfound = 1'b1;
        tsel   = 3'(t);
      end
    end
    for (int c = MAX_CHUNKS - 1; c >= 0; c--) begin
      if (!used_r[c]) begin
        nc_ok = 1'b1;
        nc    = CIW'(c);
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {ci, w1_idx_r[RIW-1:0]};
    ram_wdata = w1_data_r;
    ram_raddr = {ci, k_r[RIW-1:0]};
    unique case (state_r)
      S_W1: ram_we = w1_en_r;
      S_SHW: begin
        ram_we    = 1'b1;
        ram_waddr = {ci, j_r[RIW-1:0]};
        ram_wdata = ram_rdata;
      end
      S_W2: begin
        ram_we    = w2_en_r;
        ram_waddr = {ci, sh_k_r[RIW-1:0]};
        ram_wdata = w2_data_r;
      end
      S_SHL: ram_raddr = (sh_mode_r == SH_DOWN) ? {ci, j_up[RIW-1:0]} : {ci, j_dn[RIW-1:0]};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      chunk_size_r <= ffra_pkg::CHUNK_SIZE_RST;
      type_count_r <= ffra_pkg::TYPE_COUNT_RST;
      type_flags_r <= '0;
      used_r       <= '0;
      for (int c = 0; c < MAX_CHUNKS; c++) begin
        ctype_r[c] <= '0;
        fcnt_r[c]  <= '0;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          ffra_pkg::CFG_CHUNK_SIZE: chunk_size_r <= cfg_wdata[32:0];
          ffra_pkg::CFG_TYPE_COUNT: type_count_r <= cfg_wdata[3:0];
          ffra_pkg::CFG_TYPE_FLAGS: type_flags_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r   <= in_data;
            state_r <= (in_data.mode == ffra_pkg::MODE_ALLOC) ? S_PREP : S_RCHK;
          end
        end
        S_PREP: begin
          amask_r <= amask;
          nsz_r   <= (req_e + EW'(amask)) & ~EW'(amask);
          found_r <= tfound;
          t_r     <= tsel;
          state_r <= S_CHK;
        end
        S_CHK: begin
          c_r   <= '0;
          k_r   <= '0;
          if (!found_r) begin
            res_r <= '{status: ffra_pkg::ST_NO_TYPE, type_index: '0, chunk_index: '0,
                       block_offset: '0, block_size: '0, is_exclusive: 1'b0};
            state_r <= S_DONE;
          end else if (nsz_r > EW'(chunk_size_r)) begin
            res_r <= '{status: ffra_pkg::ST_EXCLUSIVE, type_index: t_r, chunk_index: '0,
                       block_offset: '0, block_size: bsz, is_exclusive: 1'b1};
            state_r <= S_DONE;
          end else begin
            state_r <= S_CSCAN;
          end
        end
        S_CSCAN: begin
          if (c_r == CCW'(MAX_CHUNKS)) begin
            state_r <= S_NEWCH;
          end else if (used_r[ci] && ctype_r[ci] == t_r && k_r < n_cur) begin
            state_r <= S_ARD;
          end else begin
            c_r <= c_r + CCW'(1);
            k_r <= '0;
          end
        end
        S_ARD: begin
          os_r <= rd_st_e;
          ns_r <= (rd_st_e + EW'(amask_r)) & ~EW'(amask_r);
          oe_r <= rd_end_e;
          if (EW'(rd_ln) < req_e) begin
            k_r     <= k_r + RCW'(1);
            state_r <= S_CSCAN;
          end else begin
            state_r <= S_AEV;
          end
        end
        S_AEV: begin
          if (ne > oe_r) begin
            k_r     <= k_r + RCW'(1);
            state_r <= S_CSCAN;
          end else if (ns_r != os_r && oe_r > ne && n_cur >= RCW'(MAX_RANGES)) begin
            res_r <= '{status: ffra_pkg::ST_LIST_FULL, type_index: t_r,
                       chunk_index: 4'(c_r), block_offset: '0, block_size: '0,
                       is_exclusive: 1'b0};
            state_r <= S_DONE;
          end else begin
            res_r <= '{status: ffra_pkg::ST_POOLED, type_index: t_r,
                       chunk_index: 4'(c_r), block_offset: ns_r[31:0], block_size: bsz,
                       is_exclusive: 1'b0};
            w1_idx_r  <= k_r;
            w2_data_r <= {ne[OB-1:0], oe_r[OB-1:0] - ne[OB-1:0]};
            if (ns_r == os_r) begin
              w2_en_r <= 1'b0;
              if (oe_r > ne) begin
                // shrink from the front in place
                w1_en_r   <= 1'b1;
                w1_data_r <= {ne[OB-1:0], oe_r[OB-1:0] - ne[OB-1:0]};
                sh_mode_r <= SH_NONE;
                cnt_new_r <= n_cur;
              end else begin
                w1_en_r   <= 1'b0;
                sh_mode_r <= SH_DOWN;
                j_r       <= k_r;
                cnt_new_r <= n_cur - RCW'(1);
              end
            end else begin
              w1_en_r   <= 1'b1;
              w1_data_r <= {os_r[OB-1:0], ns_r[OB-1:0] - os_r[OB-1:0]};
              if (oe_r > ne) begin
                sh_mode_r <= SH_UP;
                sh_k_r    <= k_r + RCW'(1);
                j_r       <= n_cur;
                w2_en_r   <= 1'b1;
                cnt_new_r <= n_cur + RCW'(1);
              end else begin
                sh_mode_r <= SH_NONE;
                w2_en_r   <= 1'b0;
                cnt_new_r <= n_cur;
              end
            end
            state_r <= S_W1;
          end
        end
        S_NEWCH: begin
          if (nc_ok) begin
            used_r[nc]  <= 1'b1;
            ctype_r[nc] <= t_r;
            c_r         <= CCW'(nc);
            res_r <= '{status: ffra_pkg::ST_POOLED, type_index: t_r,
                       chunk_index: 4'(nc), block_offset: '0, block_size: bsz,
                       is_exclusive: 1'b0};
            w1_en_r   <= 1'b0;
            sh_mode_r <= SH_NONE;
            sh_k_r    <= '0;
            if (EW'(chunk_size_r) > nsz_r) begin
              w2_en_r   <= 1'b1;
              w2_data_r <= {nsz_r[OB-1:0], OB'(EW'(chunk_size_r) - nsz_r)};
              cnt_new_r <= RCW'(1);
            end else begin
              w2_en_r   <= 1'b0;
              cnt_new_r <= '0;
            end
            state_r <= S_W1;
          end else begin
            res_r <= '{status: ffra_pkg::ST_NO_SLOT, type_index: t_r, chunk_index: '0,
                       block_offset: '0, block_size: '0, is_exclusive: 1'b0};
            state_r <= S_DONE;
          end
        end
        S_RCHK: begin
          res_r <= '{status: ffra_pkg::ST_RECYCLED, type_index: '0,
                     chunk_index: req_r.ret_chunk, block_offset: req_r.ret_offset,
                     block_size: 36'(req_r.ret_size), is_exclusive: req_r.ret_exclusive};
          k_r         <= '0;
          p_done_r    <= 1'b0;
          p_found_r   <= 1'b0;
          s_found_r   <= 1'b0;
          dup_r       <= 1'b0;
          pos_found_r <= 1'b0;
          if (req_r.ret_exclusive || 32'(req_r.ret_chunk) >= 32'(MAX_CHUNKS)) begin
            state_r <= S_DONE;
          end else begin
            c_r <= CCW'(req_r.ret_chunk);
            if (used_r[CIW'(req_r.ret_chunk)]) state_r <= S_RSCAN;
            else state_r <= S_DONE;
          end
        end
        S_RSCAN: begin
          res_r.type_index <= ctype_r[ci];
          state_r <= (k_r < n_cur) ? S_RRD : S_RDEC;
        end
        S_RRD: begin
          if (!p_done_r) begin
            if (rd_st_e >= rs_e) begin
              p_done_r <= 1'b1;
            end else if (rd_end_e == rs_e) begin
              p_done_r  <= 1'b1;
              p_found_r <= 1'b1;
              p_idx_r   <= k_r;
              plen_r    <= rd_ln;
              pst_r     <= rd_st;
            end
          end
          if (!s_found_r && rd_st_e == re_e) begin
            s_found_r <= 1'b1;
            s_idx_r   <= k_r;
            slen_r    <= rd_ln;
          end
          if (rd_st_e == rs_e) dup_r <= 1'b1;
          if (!pos_found_r && rd_st_e > rs_e) begin
            pos_found_r <= 1'b1;
            pos_r       <= k_r;
          end
          k_r     <= k_r + RCW'(1);
          state_r <= S_RSCAN;
        end
        S_RDEC: begin
          if (p_found_r) begin
            // merge into the preceding range, then drop the following one if it also touches
            w1_en_r   <= 1'b1;
            w2_en_r   <= 1'b0;
            w1_idx_r  <= p_idx_r;
            w1_data_r <= {pst_r, OB'(EW'(plen_r) + rsz_e +
                                    (s_found_r ? EW'(slen_r) : EW'(0)))};
            if (s_found_r) begin
              sh_mode_r <= SH_DOWN;
              j_r       <= s_idx_r;
              cnt_new_r <= n_cur - RCW'(1);
            end else begin
              sh_mode_r <= SH_NONE;
              cnt_new_r <= n_cur;
            end
            state_r <= S_W1;
          end else if (s_found_r) begin
            w1_en_r   <= 1'b1;
            w2_en_r   <= 1'b0;
            sh_mode_r <= SH_NONE;
            cnt_new_r <= n_cur;
            w1_idx_r  <= s_idx_r;
            w1_data_r <= {OB'(rs_e), OB'(EW'(slen_r) + rsz_e)};
            state_r   <= S_W1;
          end else if (dup_r) begin
            state_r <= S_DONE;
          end else if (n_cur >= RCW'(MAX_RANGES)) begin
            res_r.status <= ffra_pkg::ST_LIST_FULL;
            state_r      <= S_DONE;
          end else begin
            w1_en_r   <= 1'b0;
            sh_mode_r <= SH_UP;
            sh_k_r    <= pos_found_r ? pos_r : n_cur;
            j_r       <= n_cur;
            w2_en_r   <= 1'b1;
            w2_data_r <= {OB'(rs_e), OB'(rsz_e)};
            cnt_new_r <= n_cur + RCW'(1);
            state_r   <= S_W1;
          end
        end
        S_W1: begin
          state_r <= S_SHL;
        end
        S_SHL: begin
          unique case (sh_mode_r)
            SH_DOWN: state_r <= (j_up < n_cur) ? S_SHW : S_W2;
            SH_UP:   state_r <= (j_r > sh_k_r) ? S_SHW : S_W2;
            default: state_r <= S_W2;
          endcase
        end
        S_SHW: begin
          j_r     <= (sh_mode_r == SH_DOWN) ? j_up : j_dn;
          state_r <= S_SHL;
        end
        S_W2: begin
          fcnt_r[ci] <= cnt_new_r;
          state_r    <= S_DONE;
        end
        S_DONE: begin
          // hold until the previous result has been taken
          if (!out_valid_r || out_ready) begin
            out_data_r  <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
